@@ rtl/lati_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lati_pkg
// Shared codes and types for the log-axis table interpolator.
// ----------------------------------------------------------------------------
package lati_pkg;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Result regions
    localparam logic [1:0] REGION_EMPTY  = 2'd0;
    localparam logic [1:0] REGION_BELOW  = 2'd1;
    localparam logic [1:0] REGION_INTERP = 2'd2;
    localparam logic [1:0] REGION_ABOVE  = 2'd3;

    // Configuration register indexes and widths
    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_SC_MODE     = 1'b1;
    localparam int   CFG_DATA_W      = 5;

    // Main sequencer states
    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_CHK0  = 16'h0002,
        S_CHKL  = 16'h0004,
        S_SRCH  = 16'h0008,
        S_LO    = 16'h0010,
        S_LOGT  = 16'h0020,
        S_LOGL  = 16'h0040,
        S_LOGH  = 16'h0080,
        S_FPREP = 16'h0100,
        S_FDIV  = 16'h0200,
        S_VMUL  = 16'h0400,
        S_VFIN  = 16'h0800,
        S_RMUL  = 16'h1000,
        S_RDIVS = 16'h2000,
        S_RDIV  = 16'h4000,
        S_WAIT  = 16'h8000
    } t_state;

    // Log unit phases
    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQR  = 3'b100
    } t_log_phase;

endpackage

@@ rtl/log_axis_table_interpolator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_axis_table_interpolator_top
// Breakpoint table interpolator on a log2 temperature axis.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_stall) carries write requests, which
// store one breakpoint pair, and query requests, which produce one result on
// the output channel (o_out_valid / i_out_stall). Writes produce no result.
// Breakpoints live in two RAMs with a registered read.
// A request is taken only while the sequencer is idle; a write finishes in
// the cycle it is taken. A query against an empty table goes straight to
// the result state; one at or above the last point finishes once the first
// and last entries are checked; one below the first point takes one ratio
// step through the divider, or three in superconducting mode; an
// interpolation searches upward from index one for the upper breakpoint,
// takes the log2 of the query and of both breakpoints on the shared log2
// unit, and then, where needed, runs the 16-bit fraction divide.
// The result sits in an output register; a stalled receiver holds it and
// the next result waits in the final state until the register frees up.
// Reset clears the configuration registers and the sequencer; the table is
// undefined until written and needs no clearing pass.
// ----------------------------------------------------------------------------
module log_axis_table_interpolator_top
    import lati_pkg::*;
#(
    parameter int ENTRIES       = 16,
    parameter int LOG_FRAC_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_kind,
    input  logic [3:0]            i_entry_index,
    input  logic [31:0]           i_temperature,
    input  logic [31:0]           i_entry_value,
    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [31:0]           o_interpolated_value,
    output logic [1:0]            o_region
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = LOG_FRAC_BITS + 5;
    localparam int DW = (LW > 32) ? LW : 32;

    // Configuration
    logic [4:0] r_entry_count;
    logic       r_sc_mode;

    // Sequencer and datapath
    t_state      r_state, n_state;
    logic [31:0] r_t, r_t0, r_acc, r_thi, r_vhi, r_tlo, r_vlo, r_res;
    logic [1:0]  r_region;
    logic [AW-1:0] r_idx;
    logic [LW-1:0] r_lt, r_llo;
    logic signed [LW:0] r_num, r_den;
    logic [16:0] r_f;
    logic [63:0] r_prod;
    logic [1:0]  r_rounds;
    logic        r_up;

    // Output register
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic [1:0]  r_out_region;

    // Memory and unit wiring
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   t_rd, v_rd;
    logic          log_start, log_done;
    logic [31:0]   log_x;
    logic [LW-1:0] log_out;
    logic          div_start, div_done;
    logic [DW-1:0] div_rem, div_div;
    logic [31:0]   div_low, div_q;
    logic [5:0]    div_steps;

    logic          acc_in, out_free, den_pos;
    logic [31:0]   n_eff, cnt32;
    logic [AW-1:0] last_addr;
    logic signed [LW:0] num_c;
    logic [31:0]   diff;
    logic [48:0]   vprod;
    logic [63:0]   rprod;

    assign acc_in   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign wr_en    = acc_in && (i_kind == KIND_WRITE) && (32'(i_entry_index) < ENTRIES);

    // Breakpoint storage
    lati_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_temps (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_temperature),
        .i_raddr (rd_addr),
        .o_rdata (t_rd)
    );

    lati_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_values (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_entry_value),
        .i_raddr (rd_addr),
        .o_rdata (v_rd)
    );

    // Shared log2 unit and divider
    lati_log2 #(.LFB(LOG_FRAC_BITS)) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_log   (log_out)
    );

    lati_div #(.W(DW)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_rem     (div_rem),
        .i_low     (div_low),
        .i_divisor (div_div),
        .i_steps   (div_steps),
        .o_done    (div_done),
        .o_quot    (div_q)
    );

    // Table size in use and derived values
    always_comb begin
        cnt32     = 32'(r_entry_count);
        n_eff     = (cnt32 > ENTRIES) ? 32'(ENTRIES) : cnt32;
        last_addr = AW'(n_eff - 32'd1);
        den_pos   = !r_den[LW] && (r_den != '0);
        if (r_num[LW]) begin
            num_c = '0;
        end else if (r_num > r_den) begin
            num_c = r_den;
        end else begin
            num_c = r_num;
        end
        diff  = r_up ? (r_vhi - r_vlo) : (r_vlo - r_vhi);
        vprod = 49'(diff) * 49'(r_f);
        rprod = 64'(r_acc) * 64'(r_t);
    end

    // Sequencer next state, memory address and unit requests
    always_comb begin
        n_state   = r_state;
        rd_addr   = '0;
        log_start = 1'b0;
        log_x     = r_t;
        div_start = 1'b0;
        div_rem   = '0;
        div_low   = 32'd0;
        div_div   = '0;
        div_steps = 6'd0;
        unique case (r_state)
            S_IDLE: begin
                if (acc_in && (i_kind == KIND_QUERY)) begin
                    n_state = (n_eff == 32'd0) ? S_WAIT : S_CHK0;
                end
            end
            S_CHK0: begin
                if (r_t <= t_rd) begin
                    n_state = (t_rd == 32'd0) ? S_WAIT : S_RMUL;
                end else begin
                    rd_addr = last_addr;
                    n_state = S_CHKL;
                end
            end
            S_CHKL: begin
                if (r_t >= t_rd) begin
                    n_state = S_WAIT;
                end else begin
                    rd_addr = AW'(1);
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if ((32'(r_idx) < n_eff - 32'd1) && (t_rd < r_t)) begin
                    rd_addr = r_idx + AW'(1);
                end else begin
                    rd_addr = r_idx - AW'(1);
                    n_state = S_LO;
                end
            end
            S_LO: begin
                log_start = 1'b1;
                log_x     = r_t;
                n_state   = S_LOGT;
            end
            S_LOGT: begin
                if (log_done) begin
                    log_start = 1'b1;
                    log_x     = r_tlo;
                    n_state   = S_LOGL;
                end
            end
            S_LOGL: begin
                if (log_done) begin
                    log_start = 1'b1;
                    log_x     = r_thi;
                    n_state   = S_LOGH;
                end
            end
            S_LOGH: begin
                if (log_done) begin
                    n_state = S_FPREP;
                end
            end
            S_FPREP: begin
                if (!den_pos) begin
                    n_state = S_WAIT;
                end else if (num_c == r_den) begin
                    n_state = S_VMUL;
                end else begin
                    div_start = 1'b1;
                    div_rem   = DW'(num_c[LW-1:0]);
                    div_div   = DW'(r_den[LW-1:0]);
                    div_steps = 6'd16;
                    n_state   = S_FDIV;
                end
            end
            S_FDIV: begin
                if (div_done) begin
                    n_state = S_VMUL;
                end
            end
            S_VMUL: begin
                n_state = S_VFIN;
            end
            S_VFIN: begin
                n_state = S_WAIT;
            end
            S_RMUL: begin
                n_state = S_RDIVS;
            end
            S_RDIVS: begin
                div_start = 1'b1;
                div_rem   = DW'(r_prod[63:32]);
                div_low   = r_prod[31:0];
                div_div   = DW'(r_t0);
                div_steps = 6'd32;
                n_state   = S_RDIV;
            end
            S_RDIV: begin
                if (div_done) begin
                    n_state = (r_rounds == 2'd1) ? S_WAIT : S_RMUL;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_entry_count <= 5'd0;
            r_sc_mode     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ENTRY_COUNT: r_entry_count <= i_cfg_data[4:0];
                    REG_SC_MODE:     r_sc_mode     <= i_cfg_data[0];
                    default:         r_sc_mode     <= r_sc_mode;
                endcase
            end
            if ((r_state == S_WAIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (acc_in && (i_kind == KIND_QUERY)) begin
                    r_t      <= i_temperature;
                    r_res    <= 32'd0;
                    r_region <= REGION_EMPTY;
                end
            end
            S_CHK0: begin
                r_t0     <= t_rd;
                r_acc    <= v_rd;
                r_res    <= v_rd;
                r_region <= REGION_BELOW;
                r_rounds <= r_sc_mode ? 2'd3 : 2'd1;
            end
            S_CHKL: begin
                r_res    <= v_rd;
                r_region <= (r_t >= t_rd) ? REGION_ABOVE : REGION_INTERP;
                r_idx    <= AW'(1);
            end
            S_SRCH: begin
                if ((32'(r_idx) < n_eff - 32'd1) && (t_rd < r_t)) begin
                    r_idx <= r_idx + AW'(1);
                end else begin
                    r_thi <= t_rd;
                    r_vhi <= v_rd;
                end
            end
            S_LO: begin
                r_tlo <= t_rd;
                r_vlo <= v_rd;
            end
            S_LOGT: begin
                if (log_done) begin
                    r_lt <= log_out;
                end
            end
            S_LOGL: begin
                if (log_done) begin
                    r_llo <= log_out;
                end
            end
            S_LOGH: begin
                if (log_done) begin
                    r_den <= $signed({1'b0, log_out}) - $signed({1'b0, r_llo});
                    r_num <= $signed({1'b0, r_lt}) - $signed({1'b0, r_llo});
                end
            end
            S_FPREP: begin
                r_res <= r_vlo;
                r_f   <= 17'h10000;
                r_up  <= (r_vhi >= r_vlo);
            end
            S_FDIV: begin
                if (div_done) begin
                    r_f <= {1'b0, div_q[15:0]};
                end
            end
            S_VMUL: begin
                r_prod <= 64'(vprod);
            end
            S_VFIN: begin
                r_res <= r_up ? (r_vlo + r_prod[47:16]) : (r_vlo - r_prod[47:16]);
            end
            S_RMUL: begin
                r_prod <= rprod;
            end
            S_RDIV: begin
                if (div_done) begin
                    r_acc    <= div_q;
                    r_res    <= div_q;
                    r_rounds <= r_rounds - 2'd1;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    r_out_value  <= r_res;
                    r_out_region <= r_region;
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_in_stall           = (r_state != S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_interpolated_value = r_out_value;
    assign o_region             = r_out_region;

    // An empty table always reports zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_region == REGION_EMPTY) |-> (o_interpolated_value == 32'd0))
        else $error("empty-table result is not zero");

    // A query against an empty table goes straight to the result state.
    a_empty_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in && (i_kind == KIND_QUERY) && (n_eff == 32'd0) |=> (r_state == S_WAIT))
        else $error("empty-table query did not finish at once");

    // Leaving the result state always loads the output register.
    a_wait_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) && out_free |=> o_out_valid && (r_state == S_IDLE))
        else $error("result not delivered on leaving the result state");

    // A write request never leaves the idle state.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in && (i_kind == KIND_WRITE) |=> (r_state == S_IDLE))
        else $error("write request started a sequence");

endmodule

@@ rtl/lati_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lati_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lati_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lati_log2.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lati_log2
// Iterative fixed-point log2: a five-step normalize, then one squaring
// of the mantissa per fractional bit.
// ----------------------------------------------------------------------------
module lati_log2
    import lati_pkg::*;
#(
    parameter int LFB = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [31:0]    i_x,
    output logic           o_done,
    output logic [LFB+4:0] o_log
);

    localparam int CNTW = $clog2(LFB + 1);

    t_log_phase      r_phase;
    logic [31:0]     r_x;
    logic [4:0]      r_lz;
    logic [2:0]      r_k;
    logic [CNTW-1:0] r_cnt;
    logic [LFB-1:0]  r_frac;
    logic            r_done;

    logic [5:0]  amt;
    logic [31:0] top_bits;
    logic [63:0] sq;
    logic [32:0] sq_sh;

    // Normalize step and squaring step
    always_comb begin
        amt      = 6'(6'd1 << r_k);
        top_bits = r_x >> (6'd32 - amt);
        sq       = 64'(r_x) * 64'(r_x);
        sq_sh    = sq[63:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                L_IDLE: begin
                    if (i_start) begin
                        r_x     <= (i_x == 32'd0) ? 32'd1 : i_x;
                        r_lz    <= 5'd0;
                        r_k     <= 3'd4;
                        r_phase <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (top_bits == 32'd0) begin
                        r_x  <= r_x << amt;
                        r_lz <= r_lz + amt[4:0];
                    end
                    if (r_k == 3'd0) begin
                        r_cnt   <= CNTW'(LFB);
                        r_phase <= L_SQR;
                    end else begin
                        r_k <= r_k - 3'd1;
                    end
                end
                L_SQR: begin
                    // Mantissa squared; an overflow past two yields a one bit
                    if (sq_sh[32]) begin
                        r_x <= sq_sh[32:1];
                    end else begin
                        r_x <= sq_sh[31:0];
                    end
                    r_frac <= {r_frac[LFB-2:0], sq_sh[32]};
                    r_cnt  <= r_cnt - CNTW'(1);
                    if (r_cnt == CNTW'(1)) begin
                        r_phase <= L_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_phase <= L_IDLE;
                end
            endcase
        end
    end

    // Integer part is 31 minus the leading zero count
    assign o_done = r_done;
    assign o_log  = {~r_lz, r_frac};

endmodule

@@ rtl/lati_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lati_div
// Restoring divider, one quotient bit per cycle. The caller supplies a
// partial remainder below the divisor and the low bits to shift in.
// ----------------------------------------------------------------------------
module lati_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_rem,
    input  logic [31:0]  i_low,
    input  logic [W-1:0] i_divisor,
    input  logic [5:0]   i_steps,
    output logic         o_done,
    output logic [31:0]  o_quot
);

    logic [W-1:0] r_rem;
    logic [W-1:0] r_div;
    logic [31:0]  r_low;
    logic [31:0]  r_q;
    logic [5:0]   r_cnt;
    logic         r_busy;
    logic         r_done;

    logic [W:0] cand;
    logic       ge;

    // Trial subtraction
    always_comb begin
        cand = {r_rem, r_low[31]};
        ge   = (cand >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_rem  <= i_rem;
                r_div  <= i_divisor;
                r_low  <= i_low;
                r_q    <= 32'd0;
                r_cnt  <= i_steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? W'(cand - {1'b0, r_div}) : cand[W-1:0];
                r_q   <= {r_q[30:0], ge};
                r_low <= {r_low[30:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ verif/lati_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lati_checker
// Watches the configuration port and both channels of the log-axis table
// interpolator. It keeps its own copy of the breakpoint table and the
// registers, works out the result of every accepted query, and compares each
// accepted result with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module lati_checker
    import lati_pkg::*;
#(
    parameter int ENTRIES       = 16,
    parameter int LOG_FRAC_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_kind,
    input  logic [3:0]            i_entry_index,
    input  logic [31:0]           i_temperature,
    input  logic [31:0]           i_entry_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [31:0]           i_interpolated_value,
    input  logic [1:0]            i_region,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  region;
    } t_lookup;

    t_lookup     lookup_q[$];
    logic [31:0] table_temp [ENTRIES];
    logic [31:0] table_val  [ENTRIES];
    logic [4:0]  entry_count;
    logic        sc_mode;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        entry_count  = '0;
        sc_mode      = 1'b0;
        for (int k = 0; k < ENTRIES; k++) begin
            table_temp[k] = '0;
            table_val[k]  = '0;
        end
    end

    // Fixed-point log2: integer part from the leading one, fraction from
    // repeated squaring of the mantissa held with 31 fractional bits.
    function automatic longint log2_fixed(logic [31:0] x);
        logic [31:0] xx;
        int          p;
        logic [63:0] m;
        logic [63:0] frac;
        xx   = (x == 0) ? 32'd1 : x;
        p    = 0;
        frac = '0;
        while (p < 31 && (xx >> (p + 1)) != 0)
            p++;
        m = 64'(xx) << (31 - p);
        for (int k = 0; k < LOG_FRAC_BITS; k++) begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return longint'((64'(p) << LOG_FRAC_BITS) | frac);
    endfunction

    function automatic logic [31:0] scale_by_ratio(logic [31:0] v, logic [31:0] t,
                                                   logic [31:0] t0);
        logic [63:0] prod;
        prod = 64'(v) * 64'(t);
        return 32'(prod / 64'(t0));
    endfunction

    // Expected result of one query against the current table and registers.
    function automatic t_lookup lookup_value(logic [31:0] t);
        t_lookup     r;
        int          n;
        int          i;
        longint      num;
        longint      den;
        logic [63:0] f;
        logic [63:0] d;
        logic [31:0] vlo;
        logic [31:0] vhi;
        n = (int'(entry_count) > ENTRIES) ? ENTRIES : int'(entry_count);
        if (n == 0) begin
            r.value  = '0;
            r.region = REGION_EMPTY;
        end else if (t <= table_temp[0]) begin
            r.region = REGION_BELOW;
            if (table_temp[0] == 0) begin
                r.value = table_val[0];
            end else begin
                r.value = scale_by_ratio(table_val[0], t, table_temp[0]);
                if (sc_mode) begin
                    r.value = scale_by_ratio(r.value, t, table_temp[0]);
                    r.value = scale_by_ratio(r.value, t, table_temp[0]);
                end
            end
        end else if (t >= table_temp[n-1]) begin
            r.value  = table_val[n-1];
            r.region = REGION_ABOVE;
        end else begin
            r.region = REGION_INTERP;
            i = 1;
            while (i < n - 1 && table_temp[i] < t)
                i++;
            vlo = table_val[i-1];
            vhi = table_val[i];
            den = log2_fixed(table_temp[i]) - log2_fixed(table_temp[i-1]);
            num = log2_fixed(t) - log2_fixed(table_temp[i-1]);
            if (den <= 0) begin
                r.value = vlo;
            end else begin
                if (num < 0)
                    num = 0;
                if (num > den)
                    num = den;
                f = (64'(num) << 16) / 64'(den);
                if (vhi >= vlo) begin
                    d       = (64'(vhi - vlo) * f) >> 16;
                    r.value = vlo + 32'(d);
                end else begin
                    d       = (64'(vlo - vhi) * f) >> 16;
                    r.value = vlo - 32'(d);
                end
            end
        end
        return r;
    endfunction

    // Results are checked before new queries are queued, so a result and a
    // request on the same edge never pair up with each other.
    always @(posedge i_clk) begin
        t_lookup got;
        t_lookup want;
        if (!i_rst_n) begin
            entry_count = '0;
            sc_mode     = 1'b0;
            lookup_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.value  = i_interpolated_value;
                got.region = i_region;
                if (lookup_q.size() == 0) begin
                    $display("%0t: unexpected result value=%h region=%0d",
                             $time, got.value, got.region);
                    o_fail_count++;
                end else begin
                    want = lookup_q.pop_front();
                    o_checked++;
                    if (got.value !== want.value) begin
                        $display("%0t: value mismatch expected=%h actual=%h",
                                 $time, want.value, got.value);
                        o_fail_count++;
                    end
                    if (got.region !== want.region) begin
                        $display("%0t: region mismatch expected=%0d actual=%0d",
                                 $time, want.region, got.region);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ENTRY_COUNT: entry_count = i_cfg_data[4:0];
                    REG_SC_MODE:     sc_mode     = i_cfg_data[0];
                    default:         ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_WRITE) begin
                    if (int'(i_entry_index) < ENTRIES) begin
                        table_temp[i_entry_index] = i_temperature;
                        table_val[i_entry_index]  = i_entry_value;
                    end
                end else begin
                    lookup_q = {lookup_q, lookup_value(i_temperature)};
                end
            end
        end
        o_pending = lookup_q.size();
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the log-axis table interpolator. Loads breakpoint
// tables, sweeps the registers and sends directed and random queries under
// several idling patterns; lati_checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;
    import lati_pkg::*;

    localparam int SETTLE_CYCLES = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = REG_ENTRY_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_kind = KIND_WRITE;
    logic [3:0]            i_entry_index = '0;
    logic [31:0]           i_temperature = '0;
    logic [31:0]           i_entry_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [31:0]           o_interpolated_value;
    logic [1:0]            o_region;

    int fail_count;
    int pending;
    int checked;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    int          n_queries = 0;
    int          n_writes = 0;
    int          active_count = 0;
    logic [31:0] shadow_temp [16];

    log_axis_table_interpolator_top dut (.*);

    lati_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_kind              (i_kind),
        .i_entry_index       (i_entry_index),
        .i_temperature       (i_temperature),
        .i_entry_value       (i_entry_value),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_interpolated_value(o_interpolated_value),
        .i_region            (o_region),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_checked           (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stalls, or one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offers one request and returns in the step of its acceptance edge.
    task automatic send_request(logic kind, logic [3:0] idx, logic [31:0] t,
                                logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_entry_index <= idx;
        i_temperature <= t;
        i_entry_value <= v;
        @(posedge i_clk iff !o_in_stall);
        if (kind == KIND_WRITE) begin
            n_writes++;
            shadow_temp[idx] = t;
        end else begin
            n_queries++;
        end
    endtask

    task automatic query(logic [31:0] t);
        send_request(KIND_QUERY, 4'($urandom), t, $urandom);
    endtask

    // Waits until every outstanding result is back and the block is quiet.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_ENTRY_COUNT)
            active_count = (data > 16) ? 16 : int'(data);
        @(posedge i_clk);
    endtask

    // Writes a strictly ascending table with random spacing and values.
    task automatic load_ascending_table();
        logic [31:0] t;
        logic [31:0] span;
        span = 32'd1 << $urandom_range(4, 27);
        t    = $urandom_range(1, span);
        for (int k = 0; k < 16; k++) begin
            send_request(KIND_WRITE, 4'(k), t, $urandom);
            t = t + $urandom_range(1, span);
        end
    endtask

    // Query temperatures cluster inside the active table span.
    function automatic logic [31:0] pick_temperature();
        int          sel;
        int          k;
        logic [31:0] lo;
        logic [31:0] hi;
        sel = $urandom_range(99);
        if (sel < 55 && active_count >= 2) begin
            k  = $urandom_range(1, active_count - 1);
            lo = shadow_temp[k-1];
            hi = shadow_temp[k];
            if (hi > lo)
                return lo + $urandom_range(0, hi - lo);
            return hi;
        end else if (sel < 70 && active_count >= 1) begin
            return shadow_temp[$urandom_range(0, active_count - 1)];
        end else if (sel < 80 && active_count >= 1 && shadow_temp[0] > 1) begin
            return $urandom_range(1, shadow_temp[0]);
        end
        return $urandom_range(1, 32'hFFFF_FFFF);
    endfunction

    function automatic logic [4:0] pick_count();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd31;
            3, 4, 5: return 5'd16;
            default: return 5'($urandom_range(2, 31));
        endcase
    endfunction

    initial begin
        int sel;
        for (int k = 0; k < 16; k++)
            shadow_temp[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill the whole table first so nothing unwritten is read.
        for (int k = 0; k < 16; k++)
            send_request(KIND_WRITE, 4'(k), 32'h0001_0000 << k,
                         (k == 15) ? 32'hFFFF_FFFF : 32'h0100_0000 - 32'(k) * 32'h10_0000);
        // Empty table.
        query(32'h0004_0000);
        write_reg(REG_ENTRY_COUNT, 5'd16);
        write_reg(REG_SC_MODE, 5'd0);
        query(32'd1);
        query(32'h0000_8000);
        query(32'h0001_0000);
        query(32'h0003_0000);
        query(32'h0100_0000);
        query(32'h8000_0000);
        query(32'hFFFF_FFFF);
        write_reg(REG_SC_MODE, 5'd1);
        query(32'h0000_4000);
        query(32'd1);
        // Count beyond the table is clamped; a single entry has no span.
        write_reg(REG_ENTRY_COUNT, 5'd31);
        query(32'h0000_C000);
        query(32'hFFFF_FFFF);
        write_reg(REG_ENTRY_COUNT, 5'd1);
        query(32'h0000_8000);
        query(32'h0002_0000);
        // First breakpoint at zero temperature.
        send_request(KIND_WRITE, 4'd0, 32'd0, 32'h1234_5678);
        query(32'd0);
        // Out-of-order table, including a zero temperature inside it.
        write_reg(REG_ENTRY_COUNT, 5'd16);
        send_request(KIND_WRITE, 4'd0, 32'h0008_0000, 32'h0000_0000);
        send_request(KIND_WRITE, 4'd3, 32'd0, 32'h0055_0000);
        query(32'h0009_0000);
        query(32'h0000_0001);

        // Random: four idling patterns, several register settings each.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            drain();
            load_ascending_table();
            for (int it = 0; it < 150; it++) begin
                if (it % 50 == 0) begin
                    write_reg(REG_ENTRY_COUNT, pick_count());
                    write_reg(REG_SC_MODE, 5'($urandom_range(1)));
                end
                if (ph == 0 && it == 100)
                    hold_req = 1'b1;
                sel = $urandom_range(99);
                if (sel < 4) begin
                    load_ascending_table();
                end else if (sel < 12) begin
                    send_request(KIND_WRITE, 4'($urandom), $urandom, $urandom);
                end else begin
                    query(pick_temperature());
                end
            end
        end

        drain();
        $display("Covered %0d queries and %0d breakpoint writes, %0d results checked,",
                 n_queries, n_writes, checked);
        $display("over four idling patterns, a long output hold-off and register sweeps.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lati_pkg.sv
rtl/lati_ram.sv
rtl/lati_log2.sv
rtl/lati_div.sv
rtl/log_axis_table_interpolator_top.sv
verif/lati_checker.sv
verif/tb_top.sv
